>>> rtl/fif_pkg.sv
// ----------------------------------------------------------------------------
// fif_pkg: shared types and constants for the face interpolation factor
// Field widths, saturation limits and the control word that walks the pipeline.
// ----------------------------------------------------------------------------
package fif_pkg;

  localparam int COORD_BITS_DEF    = 32;
  localparam int FRACTION_BITS_DEF = 16;

  localparam int IN_BITS       = 32;
  localparam int NUM_COORDS    = 9;
  localparam int IN_DATA_BITS  = 288;
  localparam int WEIGHT_BITS   = 18;
  localparam int DIST_BITS     = 34;
  localparam int OUT_DATA_BITS = 56;

  localparam logic [WEIGHT_BITS-1:0] FACTOR_MAX = '1;
  localparam logic [DIST_BITS-1:0]   DIST_MAX   = '1;

  typedef struct packed {
    logic valid;
    logic last;
  } ctrl_t;

endpackage

>>> rtl/fif_norm_sq.sv
// ----------------------------------------------------------------------------
// fif_norm_sq: squared distances
// Forms both squared Euclidean distances over four register stages.
// ----------------------------------------------------------------------------
module fif_norm_sq #(
  parameter int COORD_BITS = fif_pkg::COORD_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  fif_pkg::ctrl_t                    in_ctrl,
  input  logic [2:0][fif_pkg::IN_BITS-1:0]  first_cell,
  input  logic [2:0][fif_pkg::IN_BITS-1:0]  second_cell,
  input  logic [2:0][fif_pkg::IN_BITS-1:0]  face_center,
  output fif_pkg::ctrl_t                    out_ctrl,
  output logic [2*COORD_BITS+1:0]           sum_cc,
  output logic [2*COORD_BITS+1:0]           sum_fc
);

  localparam int C  = COORD_BITS;
  localparam int S  = 2 * C + 2;
  localparam int H  = (C + 1) / 2;
  localparam int HI = C - H;

  fif_pkg::ctrl_t ctl [0:3];

  logic [C-1:0]      dif [0:5];
  logic [2*HI-1:0]   p_hh [0:5];
  logic [C-1:0]      p_hl [0:5];
  logic [2*H-1:0]    p_ll [0:5];
  logic [2*C-1:0]    sq [0:5];
  logic [S-1:0]      sum_a, sum_b;

  for (genvar j = 0; j < 6; j++) begin : g_lane
    logic [C-1:0] ca, cb, ba, bb;
    // lanes 0..2: second minus first cell; lanes 3..5: face minus second cell
    assign ca = (j < 3) ? C'(first_cell[j % 3]) : C'(second_cell[j % 3]);
    assign cb = (j < 3) ? C'(second_cell[j % 3]) : C'(face_center[j % 3]);
    assign ba = {~ca[C-1], ca[C-2:0]};
    assign bb = {~cb[C-1], cb[C-2:0]};

    always_ff @(posedge clk) begin
      if (en) begin
        dif[j]  <= (bb >= ba) ? (bb - ba) : (ba - bb);
        p_hh[j] <= (2*HI)'(dif[j][C-1:H]) * (2*HI)'(dif[j][C-1:H]);
        p_hl[j] <= C'(dif[j][C-1:H]) * C'(dif[j][H-1:0]);
        p_ll[j] <= (2*H)'(dif[j][H-1:0]) * (2*H)'(dif[j][H-1:0]);
        sq[j]   <= ((2*C)'(p_hh[j]) << (2*H)) + ((2*C)'(p_hl[j]) << (H + 1))
                   + (2*C)'(p_ll[j]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sum_a <= S'(sq[0]) + S'(sq[1]) + S'(sq[2]);
      sum_b <= S'(sq[3]) + S'(sq[4]) + S'(sq[5]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl[0].valid <= 1'b0;
      ctl[1].valid <= 1'b0;
      ctl[2].valid <= 1'b0;
      ctl[3].valid <= 1'b0;
    end else if (en) begin
      ctl[0] <= in_ctrl;
      ctl[1] <= ctl[0];
      ctl[2] <= ctl[1];
      ctl[3] <= ctl[2];
    end
  end

  assign out_ctrl = ctl[3];
  assign sum_cc   = sum_a;
  assign sum_fc   = sum_b;

endmodule

>>> rtl/fif_sqrt.sv
// ----------------------------------------------------------------------------
// fif_sqrt: pipelined integer square root, two lanes
// One root bit per stage, restoring form; both distances advance together.
// ----------------------------------------------------------------------------
module fif_sqrt #(
  parameter int COORD_BITS = fif_pkg::COORD_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    en,
  input  fif_pkg::ctrl_t          in_ctrl,
  input  logic [2*COORD_BITS+1:0] sum_cc,
  input  logic [2*COORD_BITS+1:0] sum_fc,
  output fif_pkg::ctrl_t          out_ctrl,
  output logic [COORD_BITS:0]     dist_cc,
  output logic [COORD_BITS:0]     dist_fc
);

  localparam int R = COORD_BITS + 1;
  localparam int S = 2 * COORD_BITS + 2;

  logic [S-1:0]   rem  [0:R][0:1];
  logic [R-1:0]   root [0:R][0:1];
  fif_pkg::ctrl_t ctl  [0:R];

  assign rem[0][0]  = sum_cc;
  assign rem[0][1]  = sum_fc;
  assign root[0][0] = '0;
  assign root[0][1] = '0;
  assign ctl[0]     = in_ctrl;

  for (genvar i = 0; i < R; i++) begin : g_stage
    localparam int B = R - 1 - i;
    for (genvar k = 0; k < 2; k++) begin : g_lane
      logic [S-1:0] trial;
      // (root + 2^B)^2 - root^2
      assign trial = (S'(root[i][k]) << (B + 1)) | (S'(1) << (2 * B));
      always_ff @(posedge clk) begin
        if (en) begin
          if (rem[i][k] >= trial) begin
            rem[i+1][k]  <= rem[i][k] - trial;
            root[i+1][k] <= root[i][k] | (R'(1) << B);
          end else begin
            rem[i+1][k]  <= rem[i][k];
            root[i+1][k] <= root[i][k];
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        ctl[i+1].valid <= 1'b0;
      end else if (en) begin
        ctl[i+1] <= ctl[i];
      end
    end
  end

  assign out_ctrl = ctl[R];
  assign dist_cc  = root[R][0];
  assign dist_fc  = root[R][1];

endmodule

>>> rtl/fif_divide.sv
// ----------------------------------------------------------------------------
// fif_divide: pipelined factor division and output register
// Restoring long division, one quotient bit per stage, then saturation.
// ----------------------------------------------------------------------------
module fif_divide #(
  parameter int COORD_BITS    = fif_pkg::COORD_BITS_DEF,
  parameter int FRACTION_BITS = fif_pkg::FRACTION_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  fif_pkg::ctrl_t                    in_ctrl,
  input  logic [COORD_BITS:0]               dist_cc,
  input  logic [COORD_BITS:0]               dist_fc,
  output fif_pkg::ctrl_t                    out_ctrl,
  output logic [fif_pkg::WEIGHT_BITS-1:0]   weight_factor,
  output logic [fif_pkg::DIST_BITS-1:0]     center_distance,
  output logic                              zero_distance
);

  localparam int R   = COORD_BITS + 1;
  localparam int F   = FRACTION_BITS;
  localparam int QB  = F + 2;
  localparam int DW  = R + F + 2;
  localparam int WW  = (QB > fif_pkg::WEIGHT_BITS) ? QB : fif_pkg::WEIGHT_BITS;
  localparam int DDW = (R > fif_pkg::DIST_BITS) ? R : fif_pkg::DIST_BITS;

  logic [DW-1:0]  rem  [0:QB];
  logic [R-1:0]   den  [0:QB];
  logic [QB-1:0]  quo  [0:QB];
  logic           zero [0:QB];
  logic           sat  [0:QB];
  fif_pkg::ctrl_t ctl  [0:QB+2];

  // entry stage: flag the special cases and align the dividend
  always_ff @(posedge clk) begin
    if (en) begin
      rem[0]  <= DW'(dist_fc) << F;
      den[0]  <= dist_cc;
      quo[0]  <= '0;
      zero[0] <= (dist_cc == '0);
      sat[0]  <= ((R+2)'(dist_fc) >= {dist_cc, 2'b00});
    end
  end

  for (genvar i = 0; i < QB; i++) begin : g_stage
    localparam int K = QB - 1 - i;
    logic [DW-1:0] dk;
    assign dk = DW'(den[i]) << K;
    always_ff @(posedge clk) begin
      if (en) begin
        den[i+1]  <= den[i];
        zero[i+1] <= zero[i];
        sat[i+1]  <= sat[i];
        if (rem[i] >= dk) begin
          rem[i+1] <= rem[i] - dk;
          quo[i+1] <= quo[i] | (QB'(1) << K);
        end else begin
          rem[i+1] <= rem[i];
          quo[i+1] <= quo[i];
        end
      end
    end
  end

  logic [WW-1:0]  q_ext;
  logic [DDW-1:0] d_ext;
  assign q_ext = WW'(quo[QB]);
  assign d_ext = DDW'(den[QB]);

  always_ff @(posedge clk) begin
    if (en) begin
      zero_distance <= zero[QB];
      if (zero[QB] || sat[QB] || q_ext > WW'(fif_pkg::FACTOR_MAX)) begin
        weight_factor <= fif_pkg::FACTOR_MAX;
      end else begin
        weight_factor <= q_ext[fif_pkg::WEIGHT_BITS-1:0];
      end
      if (d_ext > DDW'(fif_pkg::DIST_MAX)) begin
        center_distance <= fif_pkg::DIST_MAX;
      end else begin
        center_distance <= d_ext[fif_pkg::DIST_BITS-1:0];
      end
    end
  end

  // entry register, one per quotient bit, output register
  assign ctl[0] = in_ctrl;
  for (genvar i = 0; i <= QB + 1; i++) begin : g_ctl
    always_ff @(posedge clk) begin
      if (rst) begin
        ctl[i+1].valid <= 1'b0;
      end else if (en) begin
        ctl[i+1] <= ctl[i];
      end
    end
  end

  assign out_ctrl = ctl[QB+2];

endmodule

>>> rtl/face_interpolation_factor.sv
// ----------------------------------------------------------------------------
// face_interpolation_factor: finite-volume face interpolation factor
// Input stream of faces (two cell centers, face center), output stream of
// center distance and interpolation factor.
//
// Usage: s_* carries one face per transaction, nine signed coordinates in
// s_tdata and the last-face mark in s_tlast. m_* returns one result per
// face, in order: factor, center distance and zero-distance flag in m_tdata,
// the copied mark in m_tlast.
// Throughput: one face per cycle while the receiver does not stall. The
// pipeline has four stages of differences and squares, one stage per root
// bit of the two square roots, one per quotient bit of the divider plus
// entry and output registers.
// Reset clears all stage valid bits; the pipeline is empty afterwards.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and s_tready drops in the same cycle; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module face_interpolation_factor #(
  parameter int COORD_BITS    = fif_pkg::COORD_BITS_DEF,
  parameter int FRACTION_BITS = fif_pkg::FRACTION_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // first_cell_x/y/z, second_cell_x/y/z, face_center_x/y/z, 32 bits each
  input  logic [fif_pkg::IN_DATA_BITS-1:0]    s_tdata,
  input  logic                                s_tlast,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // weight_factor [17:0], center_distance [51:18], zero_distance [52], zeros
  output logic [fif_pkg::OUT_DATA_BITS-1:0]   m_tdata,
  output logic                                m_tlast
);

  localparam int IB = fif_pkg::IN_BITS;

  logic en;
  fif_pkg::ctrl_t in_ctrl, sq_ctrl, rt_ctrl, out_ctrl;
  logic [2:0][IB-1:0] first_cell, second_cell, face_center;
  logic [2*COORD_BITS+1:0] sum_cc, sum_fc;
  logic [COORD_BITS:0] dist_cc, dist_fc;
  logic [fif_pkg::WEIGHT_BITS-1:0] weight_factor;
  logic [fif_pkg::DIST_BITS-1:0] center_distance;
  logic zero_distance;

  // advance everything unless a result is waiting on a stalled receiver
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  assign in_ctrl.valid = s_tvalid;
  assign in_ctrl.last  = s_tlast;

  for (genvar k = 0; k < 3; k++) begin : g_unpack
    assign first_cell[k]  = s_tdata[k*IB +: IB];
    assign second_cell[k] = s_tdata[(k+3)*IB +: IB];
    assign face_center[k] = s_tdata[(k+6)*IB +: IB];
  end

  fif_norm_sq #(.COORD_BITS(COORD_BITS)) u_norm_sq (
    .clk, .rst, .en,
    .in_ctrl,
    .first_cell, .second_cell, .face_center,
    .out_ctrl (sq_ctrl),
    .sum_cc, .sum_fc
  );

  fif_sqrt #(.COORD_BITS(COORD_BITS)) u_sqrt (
    .clk, .rst, .en,
    .in_ctrl  (sq_ctrl),
    .sum_cc, .sum_fc,
    .out_ctrl (rt_ctrl),
    .dist_cc, .dist_fc
  );

  fif_divide #(.COORD_BITS(COORD_BITS), .FRACTION_BITS(FRACTION_BITS)) u_divide (
    .clk, .rst, .en,
    .in_ctrl  (rt_ctrl),
    .dist_cc, .dist_fc,
    .out_ctrl,
    .weight_factor, .center_distance, .zero_distance
  );

  assign m_tvalid = out_ctrl.valid;
  assign m_tlast  = out_ctrl.last;
  assign m_tdata  = {3'b000, zero_distance, center_distance, weight_factor};

`ifndef SYNTHESIS
  a_zero_forces_max: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && zero_distance |->
      weight_factor == fif_pkg::FACTOR_MAX && center_distance == '0)
    else $error("zero distance without forced factor");

  a_nonzero_distance: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !zero_distance |-> center_distance != '0)
    else $error("nonzero flag with zero distance");

  a_ready_follows_out: assert property (@(posedge clk) disable iff (rst)
    s_tready == (!m_tvalid || m_tready))
    else $error("input ready decoupled from output stall");

  a_empty_after_reset: assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid)
    else $error("result valid right after reset");
`endif

endmodule
